// ===== design/mol_pkg.sv =====
`timescale 1ns / 1ps

package mol_pkg;

    // register indexes on the configuration port
    localparam int unsigned CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_LEARN_EN  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_MIN_LEN   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_MAX_STEP  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_GAIN      = 3'd3;
    localparam logic [CFG_AW-1:0] REG_OFF_LIMIT = 3'd4;
    localparam int unsigned CFG_DW = 16;

    // result status codes
    localparam logic [1:0] ST_DISABLED = 2'd0;
    localparam logic [1:0] ST_FILLED   = 2'd1;
    localparam logic [1:0] ST_SMALL    = 2'd2;
    localparam logic [1:0] ST_UPDATED  = 2'd3;

    // datapath widths
    localparam int unsigned FW   = 16;  // raw field
    localparam int unsigned OW   = 21;  // offset, q8
    localparam int unsigned EW   = 17;  // history entry
    localparam int unsigned VW   = 28;  // signed vector component
    localparam int unsigned SQW  = 58;  // sum of squares
    localparam int unsigned RTW  = SQW / 2;
    localparam int unsigned PW   = 2 * VW;
    localparam int unsigned IN_DW  = 48;
    localparam int unsigned OUT_DW = 72;

    typedef logic signed [VW-1:0] t_vec;
    typedef logic signed [OW-1:0] t_off;

endpackage

// ===== design/magnetometer_offset_learner_top.sv =====
`timescale 1ns / 1ps

// Hard-iron offset learner for a three-axis magnetometer. Each input transaction
// carries one raw sample and gives exactly one output transaction with the three
// learned offsets (q8) and a status code. While learning is enabled the first
// sample fills the whole history ring; afterwards each sample is compared with the
// ring entry at the running index and, if far enough away, moves the offsets. A
// sample that changes too little finishes sooner than one that updates the offsets
// with step limiting; the time is set by the one shared 28x28 multiplier, the
// bit-serial square root (four vector lengths at most) and the radix-2 divider (up
// to four quotients). The block takes no new sample until the previous result has
// been handed to the output register.
module magnetometer_offset_learner_top #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // field_x [15:0], field_y [31:16], field_z [47:32]
    input  logic [mol_pkg::IN_DW-1:0]   i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // offset_x [20:0], offset_y [41:21], offset_z [62:42], status [64:63]
    output logic [mol_pkg::OUT_DW-1:0]  o_m_tdata,
    input  logic                        i_cfg_we,
    input  logic [mol_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [mol_pkg::CFG_DW-1:0]  i_cfg_wdata
);
    import mol_pkg::*;

    localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_PRIME, S_CALC, S_MUL, S_ACC, S_SQRT, S_SQEND, S_WRITE,
        S_DIV, S_KMUL, S_STEP, S_SCALE, S_UPDATE, S_DONE
    } t_state;

    typedef enum logic [1:0] {PH_D, PH_B2, PH_B1, PH_ST} t_phase;

    // configuration
    logic        r_learn_en;
    logic [11:0] r_min_len;
    logic [15:0] r_max_step;
    logic [15:0] r_gain;
    logic [11:0] r_lim;

    t_state r_state;
    t_phase r_phase;
    logic [IW-1:0] r_idx, r_pcnt;
    logic          r_primed;
    logic [1:0]    r_ax;
    logic [4:0]    r_it;

    logic signed [FW-1:0] r_f [3];
    t_off                 r_off [3];
    t_vec                 r_d [3];
    t_vec                 r_b1 [3];
    t_vec                 r_b2 [3];
    logic [VW-1:0]        r_stm [3];
    logic                 r_stn [3];

    logic [PW-1:0]   r_prod;
    logic [SQW-1:0]  r_acc;
    logic [SQW-1:0]  r_sqv;
    logic [RTW+1:0]  r_sqrem;
    logic [RTW-1:0]  r_root;
    logic [RTW-1:0]  r_len, r_lb2, r_slen;
    logic [RTW-1:0]  r_rem, r_den;
    logic [15:0]     r_dlo, r_q;
    logic [16:0]     r_ratio, r_kmag;
    logic            r_kneg;
    logic [1:0]      r_status;
    logic            r_ovalid;
    logic [OUT_DW-1:0] r_odata;

    // history ring
    logic [3*EW-1:0] ring [HISTORY_DEPTH];
    logic [3*EW-1:0] r_rd;
    logic            ring_we;
    logic [3*EW-1:0] ring_wd;

    logic [VW-1:0]   mul_a, mul_b, sel_mag;
    logic [PW-1:0]   mul_p;

    function automatic logic [VW-1:0] mag(input t_vec v);
        mag = v[VW-1] ? VW'(-v) : VW'(v);
    endfunction

    // offset-removed sample rounded to nearest, ties up
    function automatic logic [EW-1:0] entry_of(input logic signed [FW-1:0] f,
                                               input t_off off);
        logic signed [25:0] t;
        t = (26'(f) <<< 8) + 26'sd128 - 26'(off);
        entry_of = t[EW+7:8];
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ring_wd[EW*i +: EW] = entry_of(r_f[i], r_off[i]);
        end
    end

    assign ring_we = (r_state == S_PRIME) || (r_state == S_WRITE);

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring[(r_state == S_PRIME) ? r_pcnt : r_idx] <= ring_wd;
        end
        r_rd <= ring[r_idx];
    end

    // shared multiplier
    always_comb begin
        case (r_phase)
            PH_D:    sel_mag = mag(r_d[r_ax]);
            PH_B2:   sel_mag = mag(r_b2[r_ax]);
            PH_B1:   sel_mag = mag(r_b1[r_ax]);
            default: sel_mag = r_stm[r_ax];
        endcase
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL: begin
                mul_a = sel_mag;
                mul_b = sel_mag;
            end
            S_KMUL: begin
                mul_a = VW'(r_gain);
                mul_b = VW'(r_ratio);
            end
            S_STEP: begin
                mul_a = mag(r_d[r_ax]);
                mul_b = VW'(r_kmag);
            end
            S_SCALE: begin
                mul_a = r_stm[r_ax];
                mul_b = VW'(r_max_step);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // square root and divider step values
    logic [RTW+3:0] sq_rt, sq_tr;
    logic           sq_ge;
    logic [RTW-1:0] root_n;
    logic [RTW+1:0] sqrem_n;
    logic [RTW:0]   dv_r2;
    logic           dv_ge;
    logic [15:0]    q_n;
    logic signed [RTW+1:0] dn;
    logic [RTW:0]   dn_mag;

    always_comb begin
        sq_rt   = {r_sqrem, r_sqv[SQW-1 -: 2]};
        sq_tr   = (RTW+4)'({r_root, 2'b01});
        sq_ge   = sq_rt >= sq_tr;
        root_n  = sq_ge ? {r_root[RTW-2:0], 1'b1} : {r_root[RTW-2:0], 1'b0};
        sqrem_n = sq_ge ? (RTW+2)'(sq_rt - sq_tr) : (RTW+2)'(sq_rt);
        dv_r2   = {r_rem, r_dlo[15]};
        dv_ge   = dv_r2 >= (RTW+1)'(r_den);
        q_n     = {r_q[14:0], dv_ge};
        dn      = $signed((RTW+2)'(r_lb2)) - $signed((RTW+2)'(r_root));
        dn_mag  = dn[RTW+1] ? (RTW+1)'(-dn) : (RTW+1)'(dn);
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_en <= 1'b1;
            r_min_len  <= 12'd50;
            r_max_step <= 16'd2560;
            r_gain     <= 16'd655;
            r_lim      <= 12'd2000;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LEARN_EN:  r_learn_en <= i_cfg_wdata[0];
                REG_MIN_LEN:   r_min_len  <= i_cfg_wdata[11:0];
                REG_MAX_STEP:  r_max_step <= i_cfg_wdata;
                REG_GAIN:      r_gain     <= i_cfg_wdata;
                REG_OFF_LIMIT: r_lim      <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_D;
            r_idx    <= '0;
            r_pcnt   <= '0;
            r_primed <= 1'b0;
            r_ax     <= '0;
            r_it     <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) r_off[i] <= '0;
        end else begin
            if (r_state == S_DONE && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        for (int i = 0; i < 3; i++) r_f[i] <= i_s_tdata[FW*i +: FW];
                        r_pcnt <= '0;
                        if (!r_learn_en) begin
                            r_status <= ST_DISABLED;
                            r_state  <= S_DONE;
                        end else if (!r_primed) begin
                            r_state <= S_PRIME;
                        end else begin
                            r_state <= S_CALC;
                        end
                    end
                end
                S_PRIME: begin
                    r_pcnt <= r_pcnt + 1'b1;
                    if (r_pcnt == IW'(HISTORY_DEPTH - 1)) begin
                        r_idx    <= '0;
                        r_primed <= 1'b1;
                        r_status <= ST_FILLED;
                        r_state  <= S_DONE;
                    end
                end
                S_CALC: begin
                    for (int i = 0; i < 3; i++) begin
                        r_b1[i] <= (VW'($signed(r_rd[EW*i +: EW])) <<< 8) + VW'(r_off[i]);
                        r_b2[i] <= VW'(r_f[i]) <<< 8;
                        r_d[i]  <= (VW'(r_f[i]) <<< 8)
                                   - ((VW'($signed(r_rd[EW*i +: EW])) <<< 8) + VW'(r_off[i]));
                    end
                    r_phase <= PH_D;
                    r_ax    <= '0;
                    r_acc   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= r_acc + SQW'(r_prod);
                    if (r_ax == 2'd2) begin
                        r_sqv   <= r_acc + SQW'(r_prod);
                        r_sqrem <= '0;
                        r_root  <= '0;
                        r_it    <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_SQRT: begin
                    r_sqrem <= sqrem_n;
                    r_root  <= root_n;
                    r_sqv   <= r_sqv << 2;
                    r_it    <= r_it + 1'b1;
                    if (r_it == 5'(RTW - 1)) r_state <= S_SQEND;
                end
                S_SQEND: begin
                    r_ax  <= '0;
                    r_acc <= '0;
                    case (r_phase)
                        PH_D: begin
                            r_len <= r_root;
                            if (r_root < RTW'({r_min_len, 8'b0})) begin
                                r_idx    <= (r_idx == IW'(HISTORY_DEPTH - 1)) ? '0
                                            : r_idx + 1'b1;
                                r_status <= ST_SMALL;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_WRITE;
                            end
                        end
                        PH_B2: begin
                            r_lb2   <= r_root;
                            r_phase <= PH_B1;
                            r_state <= S_MUL;
                        end
                        PH_B1: begin
                            r_kneg <= dn[RTW+1];
                            if (r_len == '0) begin
                                r_ratio <= '0;
                                r_state <= S_KMUL;
                            end else if (dn_mag >= (RTW+1)'(r_len)) begin
                                r_ratio <= 17'h10000;
                                r_state <= S_KMUL;
                            end else begin
                                r_rem   <= RTW'(dn_mag);
                                r_dlo   <= '0;
                                r_den   <= r_len;
                                r_it    <= '0;
                                r_state <= S_DIV;
                            end
                        end
                        default: begin
                            r_slen <= r_root;
                            if (r_root > RTW'(r_max_step)) r_state <= S_SCALE;
                            else r_state <= S_UPDATE;
                        end
                    endcase
                end
                S_WRITE: begin
                    r_idx   <= (r_idx == IW'(HISTORY_DEPTH - 1)) ? '0 : r_idx + 1'b1;
                    r_phase <= PH_B2;
                    r_state <= S_MUL;
                end
                S_DIV: begin
                    r_rem <= dv_ge ? RTW'(dv_r2 - (RTW+1)'(r_den)) : RTW'(dv_r2);
                    r_dlo <= r_dlo << 1;
                    r_q   <= q_n;
                    r_it  <= r_it + 1'b1;
                    if (r_it == 5'd15) begin
                        if (r_phase == PH_B1) begin
                            r_ratio <= 17'(q_n);
                            r_state <= S_KMUL;
                        end else begin
                            r_stm[r_ax] <= VW'(q_n);
                            if (r_ax == 2'd2) begin
                                r_state <= S_UPDATE;
                            end else begin
                                r_ax    <= r_ax + 1'b1;
                                r_state <= S_SCALE;
                            end
                        end
                    end
                end
                S_KMUL: begin
                    r_kmag  <= mul_p[32:16];
                    r_ax    <= '0;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_stm[r_ax] <= mul_p[VW+15:16];
                    r_stn[r_ax] <= r_d[r_ax][VW-1] ^ r_kneg;
                    if (r_ax == 2'd2) begin
                        r_phase <= PH_ST;
                        r_ax    <= '0;
                        r_acc   <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_ax <= r_ax + 1'b1;
                    end
                end
                S_SCALE: begin
                    // quotient stays below 2^16 since the step length exceeds the limit
                    r_rem   <= RTW'(mul_p[VW+15:16]);
                    r_dlo   <= mul_p[15:0];
                    r_den   <= r_slen;
                    r_q     <= '0;
                    r_it    <= '0;
                    r_state <= S_DIV;
                end
                S_UPDATE: begin
                    for (int i = 0; i < 3; i++) begin
                        logic signed [VW+1:0] st, nv, lim;
                        st  = $signed({2'b00, r_stm[i]});
                        lim = $signed((VW+2)'({r_lim, 8'b0}));
                        nv  = (VW+2)'(r_off[i]) - (r_stn[i] ? -st : st);
                        if (nv > lim) nv = lim;
                        if (nv < -lim) nv = -lim;
                        r_off[i] <= OW'(nv);
                    end
                    r_status <= ST_UPDATED;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_odata  <= OUT_DW'({r_status, r_off[2], r_off[1], r_off[0]});
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== test/offset_learner_checker.sv =====
`timescale 1ns / 1ps

module offset_learner_checker
    import mol_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [IN_DW-1:0]          i_s_tdata,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [OUT_DW-1:0]         i_m_tdata,
    input  logic                      i_cfg_we,
    input  logic [CFG_AW-1:0]         i_cfg_addr,
    input  logic [CFG_DW-1:0]         i_cfg_wdata,
    output int                        o_mismatches,
    output int                        o_pending
);

    localparam int RING_DEPTH = 16;

    typedef struct packed {
        t_off       off_x;
        t_off       off_y;
        t_off       off_z;
        logic [1:0] status;
    } offset_result_t;

    offset_result_t expected_offsets[$];

    // predictor copy of configuration and state
    logic        learn_en;
    logic [11:0] min_len;
    logic [15:0] max_step;
    logic [15:0] gain;
    logic [11:0] off_limit;
    longint      offsets[3];
    longint      ring[RING_DEPTH][3];
    int          ring_pos;
    logic        primed;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned probe;
        res = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= res + probe) begin
                v = v - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned norm3(longint a, longint b, longint c);
        return int_sqrt(abs64(a) * abs64(a) + abs64(b) * abs64(b) + abs64(c) * abs64(c));
    endfunction

    // offset-removed sample, rounded to nearest with ties up
    function automatic longint history_value(longint f, longint off);
        return (f * 256 + 128 - off) >>> 8;
    endfunction

    task automatic learn_sample(input logic [IN_DW-1:0] data);
        longint          f[3], b1[3], b2[3], d[3], st[3];
        longint          dn, lim, n;
        longint unsigned len, r, kmag, slen, m;
        logic            kneg, neg;
        offset_result_t  res;
        f[0] = longint'($signed(data[15:0]));
        f[1] = longint'($signed(data[31:16]));
        f[2] = longint'($signed(data[47:32]));
        if (!learn_en) begin
            res.status = ST_DISABLED;
        end else if (!primed) begin
            for (int k = 0; k < RING_DEPTH; k++)
                for (int i = 0; i < 3; i++) ring[k][i] = history_value(f[i], offsets[i]);
            ring_pos = 0;
            primed = 1'b1;
            res.status = ST_FILLED;
        end else begin
            for (int i = 0; i < 3; i++) begin
                b1[i] = ring[ring_pos][i] * 256 + offsets[i];
                b2[i] = f[i] * 256;
                d[i]  = b2[i] - b1[i];
            end
            len = norm3(d[0], d[1], d[2]);
            if (len < longint'(min_len) * 256) begin
                ring_pos = (ring_pos + 1) % RING_DEPTH;
                res.status = ST_SMALL;
            end else begin
                dn = longint'(norm3(b2[0], b2[1], b2[2])) - longint'(norm3(b1[0], b1[1], b1[2]));
                kneg = dn < 0;
                lim = longint'(off_limit) * 256;
                for (int i = 0; i < 3; i++) ring[ring_pos][i] = history_value(f[i], offsets[i]);
                ring_pos = (ring_pos + 1) % RING_DEPTH;
                r = 0;
                if (len != 0) begin
                    r = (abs64(dn) << 16) / len;
                    if (r > 65536) r = 65536;
                end
                kmag = (longint'(gain) * r) >> 16;
                for (int i = 0; i < 3; i++) begin
                    m = (abs64(d[i]) * kmag) >> 16;
                    neg = (d[i] < 0) != kneg;
                    st[i] = neg ? -longint'(m) : longint'(m);
                end
                slen = norm3(st[0], st[1], st[2]);
                if (slen > longint'(max_step)) begin
                    for (int i = 0; i < 3; i++) begin
                        m = abs64(st[i]) * longint'(max_step) / slen;
                        st[i] = (st[i] < 0) ? -longint'(m) : longint'(m);
                    end
                end
                for (int i = 0; i < 3; i++) begin
                    n = offsets[i] - st[i];
                    if (n > lim) n = lim;
                    if (n < -lim) n = -lim;
                    offsets[i] = n;
                end
                res.status = ST_UPDATED;
            end
        end
        res.off_x = t_off'(offsets[0]);
        res.off_y = t_off'(offsets[1]);
        res.off_z = t_off'(offsets[2]);
        expected_offsets.push_back(res);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_mismatches++;
    endtask

    assign o_pending = expected_offsets.size();

    always @(posedge i_clk) begin
        offset_result_t want;
        t_off           gx, gy, gz;
        if (!i_rst_n) begin
            learn_en     = 1'b1;
            min_len      = 12'd50;
            max_step     = 16'd2560;
            gain         = 16'd655;
            off_limit    = 12'd2000;
            offsets      = '{0, 0, 0};
            ring_pos     = 0;
            primed       = 1'b0;
            o_mismatches = 0;
            expected_offsets.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_LEARN_EN:  learn_en  = i_cfg_wdata[0];
                    REG_MIN_LEN:   min_len   = i_cfg_wdata[11:0];
                    REG_MAX_STEP:  max_step  = i_cfg_wdata;
                    REG_GAIN:      gain      = i_cfg_wdata;
                    REG_OFF_LIMIT: off_limit = i_cfg_wdata[11:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                gx = i_m_tdata[20:0];
                gy = i_m_tdata[41:21];
                gz = i_m_tdata[62:42];
                if (expected_offsets.size() == 0) begin
                    report("unexpected transaction status", i_m_tdata[64:63], -1);
                end else begin
                    want = expected_offsets.pop_front();
                    if (gx != want.off_x) report("offset_x", gx, want.off_x);
                    if (gy != want.off_y) report("offset_y", gy, want.off_y);
                    if (gz != want.off_z) report("offset_z", gz, want.off_z);
                    if (i_m_tdata[64:63] != want.status)
                        report("status", i_m_tdata[64:63], want.status);
                end
            end
            if (i_s_tvalid && i_s_tready) learn_sample(i_s_tdata);
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mol_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_DW-1:0]    s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_DW-1:0]   m_tdata;
    logic                cfg_we;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [CFG_DW-1:0]   cfg_wdata;
    int                  mismatches;
    int                  pending;
    int                  cycles;
    logic                long_hold_req;

    // hard-iron sphere used for well-formed samples
    int center[3];
    int radius;

    magnetometer_offset_learner_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    offset_learner_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(80, 10);
    endfunction

    // receiver: random stalls, plus one long hold-off once requested
    initial begin
        int   stall;
        logic held_once;
        held_once = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !held_once) begin
                held_once = 1'b1;
                m_tready <= 1'b0;
                repeat (3000) @(negedge i_clk);
            end
            stall = gap_len();
            if (stall == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    task automatic send_sample(input int fx, input int fy, input int fz);
        int gap;
        s_tdata  <= {16'(fz), 16'(fy), 16'(fx)};
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        gap = gap_len();
        if ($urandom_range(3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input int value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value[CFG_DW-1:0];
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
    endtask

    task automatic apply_settings(input int en, input int min_len, input int max_step,
                                  input int gain, input int limit);
        write_reg(REG_LEARN_EN, en);
        write_reg(REG_MIN_LEN, min_len);
        write_reg(REG_MAX_STEP, max_step);
        write_reg(REG_GAIN, gain);
        write_reg(REG_OFF_LIMIT, limit);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            send_sample($urandom, $urandom, $urandom);
        end else if (roll < 20) begin
            // near repeat of the sphere center, tends to give a small change
            send_sample(center[0] + $urandom_range(10) - 5, center[1] + $urandom_range(10) - 5,
                        center[2] + $urandom_range(10) - 5);
        end else begin
            if ($urandom_range(40) == 0) begin
                center[0] = $urandom_range(3000) - 1500;
                center[1] = $urandom_range(3000) - 1500;
                center[2] = $urandom_range(3000) - 1500;
                radius    = $urandom_range(2000, 200);
            end
            send_sample(center[0] + $urandom_range(2 * radius) - radius,
                        center[1] + $urandom_range(2 * radius) - radius,
                        center[2] + $urandom_range(2 * radius) - radius);
        end
    endtask

    task automatic run_phase(input int count);
        repeat (count) random_sample();
        settle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        long_hold_req = 1'b0;
        center        = '{300, -200, 100};
        radius        = 800;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: priming, field extremes, small change, disabled
        send_sample(32767, 32767, 32767);
        send_sample(-32768, -32768, -32768);
        send_sample(0, 0, 0);
        send_sample(32767, -32768, 0);
        send_sample(-32768, 32767, 1);
        send_sample(-32768, 32767, 1);
        send_sample(32767, -32768, 0);
        settle();
        apply_settings(0, 50, 2560, 655, 2000);
        send_sample(1000, -1000, 500);
        send_sample(-5, 7, 32767);
        settle();
        // zero difference with threshold zero still replaces the entry
        apply_settings(1, 0, 65535, 65535, 4095);
        send_sample(123, -456, 789);
        send_sample(123, -456, 789);
        repeat (16) send_sample(123, -456, 789);
        settle();

        // long receiver hold-off while the sender keeps offering
        long_hold_req <= 1'b1;
        @(negedge i_clk);
        run_phase(160);
        apply_settings(1, 4095, 2560, 655, 2000);
        run_phase(120);
        apply_settings(1, 10, 0, 30000, 100);
        run_phase(160);
        apply_settings(1, 20, 65535, 65535, 0);
        run_phase(130);
        apply_settings(0, 0, 1, 1, 4095);
        run_phase(60);
        apply_settings(1, 1, 300, 20000, 4095);
        run_phase(160);
        apply_settings(1, 50, 2560, 655, 2000);
        run_phase(160);

        if (mismatches == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/mol_pkg.sv
design/magnetometer_offset_learner_top.sv
test/offset_learner_checker.sv
test/testbench.sv
